[rtl/aspnf_pkg.sv]
// aspnf_pkg: shared types and constants for the adjacent scan peak neighbor filter
// no dependencies

package aspnf_pkg;

  localparam int ROW_CAPACITY_DEFAULT = 32;

  localparam logic [1:0] ACT_PEAK   = 2'd0;
  localparam logic [1:0] ACT_EOR    = 2'd1;
  localparam logic [1:0] ACT_EOM    = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  localparam logic [1:0] VERDICT_HIT   = 2'd0;
  localparam logic [1:0] VERDICT_MISS  = 2'd1;
  localparam logic [1:0] VERDICT_BELOW = 2'd2;
  localparam logic [1:0] VERDICT_FULL  = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;

  localparam logic [31:0] TOLERANCE_RESET = 32'd1311;

  // queued command from the front to the back
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] mz;
    logic [31:0] intensity;
  } cmd_t;

  typedef struct packed {
    logic [15:0] row_number;
    logic [15:0] peak_number;
    logic        keep;
    logic [1:0]  verdict;
    logic        last_of_run;
  } result_t;

endpackage

[rtl/aspnf_if.sv]
// aspnf_in_if / aspnf_out_if: valid-ready channels of the filter
// depends on nothing

interface aspnf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] mz;
  logic [31:0] intensity;
  modport source (output valid, action, mz, intensity, input ready);
  modport sink (input valid, action, mz, intensity, output ready);
endinterface

interface aspnf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_number;
  logic [15:0] peak_number;
  logic        keep;
  logic [1:0]  verdict;
  logic        last_of_run;
  modport source (output valid, row_number, peak_number, keep, verdict, last_of_run,
                  input ready);
  modport sink (input valid, row_number, peak_number, keep, verdict, last_of_run,
                output ready);
endinterface

[rtl/aspnf_front.sv]
// aspnf_front: accepts input beats, drops action three, queues the rest
// depends on aspnf_pkg

module aspnf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aspnf_pkg::cmd_t     in_cmd,
  output logic                q_valid,
  input  logic                q_ready,
  output aspnf_pkg::cmd_t     q_cmd
);

  // two entry queue
  aspnf_pkg::cmd_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop, useful;

  assign in_ready = (count != 2'd2);
  assign useful   = (in_cmd.action != aspnf_pkg::ACT_IGNORE);
  assign push     = in_valid && in_ready && useful;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/aspnf_back.sv]
// aspnf_back: row stores, neighbor compare sequencer and result register
// depends on aspnf_pkg

module aspnf_back #(
  parameter int ROW_CAPACITY = aspnf_pkg::ROW_CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  aspnf_pkg::cmd_t     q_cmd,
  input  logic [31:0]         threshold,
  input  logic [23:0]         tolerance,
  output logic                res_valid,
  input  logic                res_ready,
  output aspnf_pkg::result_t  res
);

  localparam int IW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int CW = $clog2(ROW_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(ROW_CAPACITY);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_EMITP = 3'd2;
  localparam logic [2:0] ST_EMITC = 3'd3;
  localparam logic [2:0] ST_SWAP  = 3'd4;

  // two banks; bank sel is current row, other is previous
  logic [31:0] mz_mem  [2][ROW_CAPACITY];
  logic [15:0] idx_mem [2][ROW_CAPACITY];
  logic [ROW_CAPACITY-1:0] hit [2];
  logic [CW-1:0] cnt [2];
  logic          sel;

  logic [2:0]    state;
  logic [15:0]   row_counter, peak_counter;
  logic [IW-1:0] ptr;
  logic [CW-1:0] ptr_ext;
  logic [31:0]   cur_mz;
  logic          cur_hit;
  logic          is_eom;

  logic [31:0] other, diff;
  logic        near;
  logic        prv;
  logic        out_free;
  logic        take;
  logic        drop;
  logic        emit_bank;
  logic        res_load;

  assign prv       = ~sel;
  assign out_free  = !res_valid || res_ready;
  assign q_ready   = (state == ST_IDLE) && out_free;
  assign take      = q_valid && q_ready;
  assign ptr_ext   = CW'(ptr);
  assign other     = mz_mem[prv][ptr];
  assign diff      = (cur_mz >= other) ? cur_mz - other : other - cur_mz;
  assign near      = diff <= {8'd0, tolerance};
  assign drop      = (q_cmd.intensity <= threshold) || (cnt[sel] >= CAP);
  assign emit_bank = (state == ST_EMITP) ? prv : sel;
  // a result beat is loaded on a dropped peak or on each emitted verdict
  assign res_load  = (take && q_cmd.action == aspnf_pkg::ACT_PEAK && drop) ||
                     ((state == ST_EMITP || state == ST_EMITC) && out_free &&
                      ptr_ext < cnt[emit_bank]);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sel          <= 1'b0;
      cnt[0]       <= '0;
      cnt[1]       <= '0;
      hit[0]       <= '0;
      hit[1]       <= '0;
      row_counter  <= '0;
      peak_counter <= '0;
      ptr          <= '0;
      is_eom       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            unique case (q_cmd.action)
              aspnf_pkg::ACT_PEAK: begin
                peak_counter <= peak_counter + 16'd1;
                if (drop) begin
                  res.row_number  <= row_counter;
                  res.peak_number <= peak_counter;
                  res.keep        <= 1'b0;
                  res.verdict     <= (q_cmd.intensity <= threshold) ?
                                     aspnf_pkg::VERDICT_BELOW : aspnf_pkg::VERDICT_FULL;
                  res.last_of_run <= 1'b1;
                end else begin
                  cur_mz  <= q_cmd.mz;
                  cur_hit <= 1'b0;
                  ptr     <= '0;
                  state   <= ST_CMP;
                end
              end
              aspnf_pkg::ACT_EOR, aspnf_pkg::ACT_EOM: begin
                is_eom <= (q_cmd.action == aspnf_pkg::ACT_EOM);
                ptr    <= '0;
                state  <= ST_EMITP;
              end
              default: ;
            endcase
          end
        end
        // one previous-row entry per cycle
        ST_CMP: begin
          if (ptr_ext >= cnt[prv]) begin
            mz_mem[sel][cnt[sel][IW-1:0]]  <= cur_mz;
            idx_mem[sel][cnt[sel][IW-1:0]] <= peak_counter - 16'd1;
            hit[sel][cnt[sel][IW-1:0]]     <= cur_hit;
            cnt[sel] <= cnt[sel] + 1'b1;
            state    <= ST_IDLE;
          end else begin
            if (near) begin
              hit[prv][ptr] <= 1'b1;
              cur_hit       <= 1'b1;
            end
            ptr <= (ptr_ext + 1'b1 >= CAP) ? ptr : ptr + 1'b1;
            if (ptr_ext + 1'b1 >= CAP) begin
              mz_mem[sel][cnt[sel][IW-1:0]]  <= cur_mz;
              idx_mem[sel][cnt[sel][IW-1:0]] <= peak_counter - 16'd1;
              hit[sel][cnt[sel][IW-1:0]]     <= cur_hit || near;
              cnt[sel] <= cnt[sel] + 1'b1;
              state    <= ST_IDLE;
            end
          end
        end
        ST_EMITP, ST_EMITC: begin
          if (out_free) begin
            if (ptr_ext >= cnt[(state == ST_EMITP) ? prv : sel]) begin
              ptr <= '0;
              if (state == ST_EMITP && is_eom) state <= ST_EMITC;
              else state <= ST_SWAP;
            end else begin
              res.row_number  <= (state == ST_EMITP) ? row_counter - 16'd1 : row_counter;
              res.peak_number <= idx_mem[(state == ST_EMITP) ? prv : sel][ptr];
              res.keep        <= hit[(state == ST_EMITP) ? prv : sel][ptr];
              res.verdict     <= hit[(state == ST_EMITP) ? prv : sel][ptr] ?
                                 aspnf_pkg::VERDICT_HIT : aspnf_pkg::VERDICT_MISS;
              // last when nothing follows in this run
              res.last_of_run <= (ptr_ext + 1'b1 >= cnt[(state == ST_EMITP) ? prv : sel]) &&
                                 !(state == ST_EMITP && is_eom && cnt[sel] != '0);
              if (ptr_ext + 1'b1 >= CAP) begin
                ptr <= '0;
                if (state == ST_EMITP && is_eom) state <= ST_EMITC;
                else state <= ST_SWAP;
              end else begin
                ptr <= ptr + 1'b1;
              end
            end
          end
        end
        ST_SWAP: begin
          peak_counter <= '0;
          hit[prv]     <= '0;
          cnt[prv]     <= '0;
          if (is_eom) begin
            hit[sel]    <= '0;
            cnt[sel]    <= '0;
            row_counter <= '0;
          end else begin
            sel         <= prv;
            row_counter <= row_counter + 16'd1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/adjacent_scan_peak_neighbor_filter.sv]
// adjacent_scan_peak_neighbor_filter: top level, config registers and the two halves
// depends on aspnf_pkg, aspnf_if, aspnf_front, aspnf_back

// A beat is written into the two-beat front queue before the back can take it.
// A stored peak holds the back while the single compare unit walks the previous
// row store, then writes the peak into the current row store. A dropped peak
// needs the result register free. End of row holds the back while it emits a
// verdict for each previous-row peak; end of map also emits the current row and
// then clears both rows. Output stalls hold the sequencer; the front queue
// accepts beats while the back works, until both of its entries are full.
module adjacent_scan_peak_neighbor_filter #(
  parameter int ROW_CAPACITY = aspnf_pkg::ROW_CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  aspnf_in_if.sink    in_ch,
  aspnf_out_if.source out_ch
);

  logic [31:0] threshold;
  logic [23:0] tolerance;
  aspnf_pkg::cmd_t    in_cmd, q_cmd;
  aspnf_pkg::result_t res;
  logic q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      tolerance <= aspnf_pkg::TOLERANCE_RESET[23:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        aspnf_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        aspnf_pkg::CFG_TOLERANCE: tolerance <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign in_cmd.action    = in_ch.action;
  assign in_cmd.mz        = in_ch.mz;
  assign in_cmd.intensity = in_ch.intensity;

  aspnf_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  aspnf_back #(.ROW_CAPACITY(ROW_CAPACITY)) u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_cmd,
    .threshold, .tolerance,
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res
  );

  assign out_ch.row_number  = res.row_number;
  assign out_ch.peak_number = res.peak_number;
  assign out_ch.keep        = res.keep;
  assign out_ch.verdict     = res.verdict;
  assign out_ch.last_of_run = res.last_of_run;

endmodule
